// ===== src/tss_pkg.sv =====
// Shared types, constants and code helpers for the tone-squelch register sequencer.
`default_nettype none
package tss_pkg;

  localparam logic [2:0] OpOff       = 3'd0;
  localparam logic [2:0] OpCtcss     = 3'd1;
  localparam logic [2:0] OpDcsNormal = 3'd2;
  localparam logic [2:0] OpDcsInvert = 3'd3;
  localparam logic [2:0] OpCustom    = 3'd4;

  localparam logic [1:0] CfgCtcssNarrow = 2'd0;
  localparam logic [1:0] CfgCtcssWide   = 2'd1;
  localparam logic [1:0] CfgDcsNarrow   = 2'd2;
  localparam logic [1:0] CfgDcsWide     = 2'd3;

  localparam logic [6:0] RegEnable = 7'h51;
  localparam logic [6:0] RegTone   = 7'h07;
  localparam logic [6:0] RegCode   = 7'h08;

  localparam logic [15:0] CtcssEnable  = 16'h9000;
  localparam logic [15:0] DcsEnable    = 16'h8000;
  localparam logic [15:0] DcsInvEnable = 16'hA000;
  localparam logic [15:0] LongCodeFlag = 16'h0800;
  localparam logic [15:0] DcsRateWord  = 16'd2775;
  localparam logic [15:0] CodeHighFlag = 16'h8000;

  localparam logic [11:0] GolayPoly    = 12'hAE3;
  localparam logic [11:0] DcsNormBase  = 12'h800;
  localparam logic [11:0] DcsInvBase   = 12'hA00;
  localparam logic [8:0]  DcsInvMask   = 9'h028;
  localparam logic [22:0] DcsInvFlip   = 23'h000200;

  localparam logic [8:0]  ToneMul   = 9'd413;
  localparam logic [30:0] ToneRecip = 31'd1374389535;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KindOff,
    KindTone,
    KindCode
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] gain_word;
    logic [23:0] payload;
  } entry_t;

  function automatic logic [10:0] golay_par(input int j);
    logic [22:0] r;
    logic [10:0] p;
    r = 23'(1) << (22 - j);
    for (int i = 0; i < 12; i++) begin
      if (r[22 - i]) begin
        r = r ^ (23'(GolayPoly) << (11 - i));
      end
    end
    for (int t = 0; t < 11; t++) begin
      p[t] = r[10 - t];
    end
    return p;
  endfunction

  function automatic logic [22:0] golay_cw(input logic [11:0] w);
    logic [10:0] par;
    par = '0;
    for (int j = 0; j < 12; j++) begin
      if (w[j]) begin
        par = par ^ golay_par(j);
      end
    end
    return {par, w};
  endfunction

endpackage
`default_nettype wire

// ===== src/tss_front.sv =====
// Front end: configuration registers, request intake, classification and word math.
`default_nettype none
module tss_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [23:0]        code_i,
  input  wire logic [1:0]         encrypt_i,
  input  wire logic               narrow_i,
  input  wire logic               long_code_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output tss_pkg::entry_t         push_entry_o
);

  logic [10:0] ctcss_narrow_q, ctcss_wide_q, dcs_narrow_q, dcs_wide_q;

  logic        v1_q;
  logic [2:0]  op1_q;
  logic [23:0] code1_q;
  logic [1:0]  enc1_q;
  logic        nar1_q, lng1_q;

  logic            v2_q;
  tss_pkg::kind_e  kind2_q;
  logic [15:0]     gain2_q;
  logic [23:0]     cw2_q;
  logic [32:0]     prod2_q;

  logic            adv2;
  logic            op_ok;
  tss_pkg::kind_e  kind1;
  logic [15:0]     gain1;
  logic [23:0]     cw1;
  logic [32:0]     prod1;
  logic [10:0]     cgain, dgain;
  logic            inv;
  logic [11:0]     word;
  logic [60:0]     quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctcss_narrow_q <= '0;
      ctcss_wide_q   <= '0;
      dcs_narrow_q   <= '0;
      dcs_wide_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tss_pkg::CfgCtcssNarrow: ctcss_narrow_q <= cfg_data_i;
        tss_pkg::CfgCtcssWide:   ctcss_wide_q   <= cfg_data_i;
        tss_pkg::CfgDcsNarrow:   dcs_narrow_q   <= cfg_data_i;
        tss_pkg::CfgDcsWide:     dcs_wide_q     <= cfg_data_i;
      endcase
    end
  end

  assign adv2       = !v2_q || push_ready_i;
  assign in_ready_o = !v1_q || adv2;

  always_comb begin
    cgain = nar1_q ? ctcss_narrow_q : ctcss_wide_q;
    dgain = nar1_q ? dcs_narrow_q : dcs_wide_q;
    inv   = enc1_q[0];
    word  = inv ? ({3'b000, code1_q[8:0] ^ tss_pkg::DcsInvMask} + tss_pkg::DcsInvBase)
                : ({3'b000, code1_q[8:0]} + tss_pkg::DcsNormBase);
    prod1 = 33'(code1_q) * 33'(tss_pkg::ToneMul);
    op_ok = 1'b1;
    kind1 = tss_pkg::KindOff;
    gain1 = '0;
    cw1   = '0;
    unique case (op1_q)
      tss_pkg::OpOff: begin
        kind1 = tss_pkg::KindOff;
      end
      tss_pkg::OpCtcss: begin
        kind1 = tss_pkg::KindTone;
        gain1 = tss_pkg::CtcssEnable | {5'b00000, cgain};
      end
      tss_pkg::OpDcsNormal, tss_pkg::OpDcsInvert: begin
        kind1 = tss_pkg::KindCode;
        gain1 = ((op1_q == tss_pkg::OpDcsInvert) ? tss_pkg::DcsInvEnable : tss_pkg::DcsEnable)
                | {5'b00000, dgain};
        cw1   = {1'b0, tss_pkg::golay_cw(word) ^ (inv ? tss_pkg::DcsInvFlip : 23'h0)};
      end
      tss_pkg::OpCustom: begin
        kind1 = tss_pkg::KindCode;
        gain1 = tss_pkg::DcsEnable | {5'b00000, dgain}
                | (lng1_q ? tss_pkg::LongCodeFlag : 16'h0000);
        cw1   = code1_q;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q && op_ok;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op1_q   <= op_i;
      code1_q <= code_i;
      enc1_q  <= encrypt_i;
      nar1_q  <= narrow_i;
      lng1_q  <= long_code_i;
    end
    if (adv2 && v1_q) begin
      kind2_q <= kind1;
      gain2_q <= gain1;
      cw2_q   <= cw1;
      prod2_q <= prod1;
    end
  end

  assign quot = 61'(prod2_q[32:3]) * 61'(tss_pkg::ToneRecip);

  always_comb begin
    push_valid_o           = v2_q;
    push_entry_o.kind      = kind2_q;
    push_entry_o.gain_word = gain2_q;
    push_entry_o.payload   = (kind2_q == tss_pkg::KindTone) ? {11'b0, quot[47:35]} : cw2_q;
  end

endmodule
`default_nettype wire

// ===== src/tss_queue.sv =====
// Two-entry queue that decouples the front end from the write sequencer.
`default_nettype none
module tss_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  tss_pkg::entry_t         push_entry_i,
  input  wire logic               pop_i,
  output logic                    head_valid_o,
  output tss_pkg::entry_t         head_o
);

  localparam int PtrW = $clog2(tss_pkg::QueueDepth);

  tss_pkg::entry_t mem_q [tss_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != (PtrW + 1)'(tss_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(tss_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(tss_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tss_back.sv =====
// Back end: steps through the register writes of the queue head into an output register.
`default_nettype none
module tss_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               head_valid_i,
  input  tss_pkg::entry_t         head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [6:0]              reg_addr_o,
  output logic [15:0]             reg_data_o,
  output logic                    last_o
);

  logic        out_valid_q;
  logic [6:0]  addr_q;
  logic [15:0] data_q;
  logic        last_q;
  logic [1:0]  idx_q, idx_d;
  logic        load;
  logic [6:0]  addr_d;
  logic [15:0] data_d;
  logic        last_d;

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    addr_d = tss_pkg::RegEnable;
    data_d = head_i.gain_word;
    last_d = 1'b0;
    unique case (head_i.kind)
      tss_pkg::KindOff: begin
        data_d = '0;
        last_d = 1'b1;
      end
      tss_pkg::KindTone: begin
        if (idx_q != 2'd0) begin
          addr_d = tss_pkg::RegTone;
          data_d = head_i.payload[15:0];
          last_d = 1'b1;
        end
      end
      tss_pkg::KindCode: begin
        unique case (idx_q)
          2'd0: begin
            addr_d = tss_pkg::RegEnable;
          end
          2'd1: begin
            addr_d = tss_pkg::RegTone;
            data_d = tss_pkg::DcsRateWord;
          end
          2'd2: begin
            addr_d = tss_pkg::RegCode;
            data_d = {4'b0000, head_i.payload[11:0]};
          end
          2'd3: begin
            addr_d = tss_pkg::RegCode;
            data_d = tss_pkg::CodeHighFlag | {4'b0000, head_i.payload[23:12]};
            last_d = 1'b1;
          end
        endcase
      end
      default: begin
        last_d = 1'b1;
      end
    endcase
    pop_o = load && head_valid_i && last_d;
    idx_d = idx_q;
    if (load && head_valid_i) begin
      idx_d = last_d ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_addr_o  = addr_q;
  assign reg_data_o  = data_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== src/tone_squelch_register_sequencer.sv =====
// Top level of the tone-squelch register sequencer.
// Each request on the input channel (op, code, encrypt, narrow, long_code) turns into
// a sequence of transceiver register writes on the output channel, one transaction
// per write, with last_o marking the final write of the request. Off gives one
// write, CTCSS two, DCS and custom codes four; unknown ops give none.
// The configuration channel writes the four gain registers; it is always ready and
// should only be used while no request is in flight.
// The first write of a request passes through both front-end stages, the queue and
// the back-end output register. The front end takes one request per cycle while its
// output is not stalled, through two register stages (intake with classification and
// tone product, then a stage that holds the product and feeds the reciprocal divide)
// into a two-entry queue. The back end issues one write per cycle while the receiver
// is ready, and pops a request from the queue as it loads that request's last write.
// When the receiver stalls, the output register holds its write, the queue fills,
// and the input ready drops once the pipeline behind it is full.
// Reset clears the gain registers to zero and empties the pipeline and queue.
`default_nettype none
module tone_squelch_register_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [23:0] code_i,
  input  wire logic [1:0]  encrypt_i,
  input  wire logic        narrow_i,
  input  wire logic        long_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       reg_addr_o,
  output logic [15:0]      reg_data_o,
  output logic             last_o
);

  logic            push_valid, push_ready, head_valid, pop;
  tss_pkg::entry_t push_entry, head;

  assign cfg_ready_o = 1'b1;

  tss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .code_i       (code_i),
    .encrypt_i    (encrypt_i),
    .narrow_i     (narrow_i),
    .long_code_i  (long_code_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  tss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reg_addr_o   (reg_addr_o),
    .reg_data_o   (reg_data_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// ===== src/tss_checker.sv =====
// Port-level checker for the tone-squelch register sequencer and its bind statement.
`default_nettype none
module tss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [6:0]  reg_addr_o,
  input wire logic [15:0] reg_data_o,
  input wire logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reg_data_o) && $stable(last_o))
    else $error("Output transaction changed while stalled.");

  a_addr_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reg_addr_o == tss_pkg::RegEnable) || (reg_addr_o == tss_pkg::RegTone)
                    || (reg_addr_o == tss_pkg::RegCode))
    else $error("Write to an unexpected register.");

  a_code_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reg_addr_o == tss_pkg::RegCode)
      |-> (reg_data_o[15:12] == (last_o ? 4'h8 : 4'h0)))
    else $error("Code half carries the wrong flag.");

  a_code_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=>
      !(out_valid_o && (reg_addr_o == tss_pkg::RegCode)))
    else $error("Code write started a new request.");

endmodule

bind tone_squelch_register_sequencer tss_checker u_tss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .reg_addr_o  (reg_addr_o),
  .reg_data_o  (reg_data_o),
  .last_o      (last_o)
);
`default_nettype wire
